// ===== sv/bse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and command codes for the bit string engine.
// No dependencies.
package bse_pkg;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_FILL  = 3'd2,
    OP_MOVE  = 3'd3,
    OP_CMP   = 3'd4,
    OP_ZERO  = 3'd5
  } op_t;

  // Store port control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  localparam logic signed [1:0] CMP_EQ   = 2'sd0;
  localparam logic signed [1:0] CMP_GT   = 2'sd1;
  localparam logic signed [1:0] CMP_LT   = -2'sd1;

endpackage

// ===== sv/bse_store.sv =====
`timescale 1ns / 1ps
// Single-port byte store, registered read data.
// Depends on bse_pkg.
module bse_store #(
  parameter int DEPTH = 4096,
  parameter int ABW   = 12
) (
  input  logic              clk,
  input  bse_pkg::mem_ctl_t ctl,
  input  logic [ABW-1:0]    addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);
  import bse_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bse_ctrl.sv =====
`timescale 1ns / 1ps
// Command sequencer: decodes commands, walks strings bit by bit with
// read-modify-write on the store. Depends on bse_pkg.
module bse_ctrl #(
  parameter int STORE_BYTES = 4096,
  parameter int ABW         = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_operation,
  input  logic [11:0]             in_byte_address,
  input  logic [7:0]              in_write_data,
  input  logic [14:0]             in_first_bit_address,
  input  logic [14:0]             in_second_bit_address,
  input  logic [15:0]             in_bit_count,
  input  logic                    in_fill_bit,
  output bse_pkg::mem_ctl_t       mem_ctl,
  output logic [ABW-1:0]          mem_addr,
  output logic [7:0]              mem_wdata,
  input  logic [7:0]              mem_rdata,
  output logic                    out_strobe,
  output logic [7:0]              out_read_data,
  output logic signed [1:0]       out_compare_result,
  output logic                    out_all_zero,
  output logic                    out_range_error
);
  import bse_pkg::*;

  localparam int unsigned STORE_BITS = STORE_BYTES * 8;

  typedef enum logic [2:0] {ST_IDLE, ST_BREAD, ST_RDA, ST_RDB, ST_EXEC} state_t;

  state_t             state_r;
  op_t                op_r;
  logic [14:0]        a1_r, a2_r;
  logic [15:0]        off_r, left_r;
  logic               fwd_r, fill_r, bita_r;
  logic               strobe_r, az_r, err_r;
  logic [7:0]         rd_r;
  logic signed [1:0]  cmp_r;

  op_t         in_op;
  logic        byte_ok, fit1, fit2;
  logic [16:0] pos_first, pos_second;
  logic [2:0]  bsel;
  logic        bit_b, new_bit;
  logic [7:0]  bmask;

  assign in_op   = op_t'(in_operation);
  assign byte_ok = 32'(in_byte_address) < STORE_BYTES;
  assign fit1    = 32'(17'(in_first_bit_address) + 17'(in_bit_count)) <= STORE_BITS;
  assign fit2    = 32'(17'(in_second_bit_address) + 17'(in_bit_count)) <= STORE_BITS;

  assign pos_first  = (op_r == OP_MOVE) ? 17'(a2_r) + 17'(off_r) : 17'(a1_r) + 17'(off_r);
  assign pos_second = (op_r == OP_CMP)  ? 17'(a2_r) + 17'(off_r) : 17'(a1_r) + 17'(off_r);
  assign bsel       = pos_second[2:0];
  assign bit_b      = mem_rdata[3'd7 - bsel];
  assign new_bit    = (op_r == OP_FILL) ? fill_r : bita_r;
  assign bmask      = 8'h80 >> bsel;

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = ABW'(in_byte_address);
    mem_wdata = in_write_data;
    unique case (state_r)
      ST_IDLE: begin
        if (start && byte_ok) begin
          mem_ctl.wr_en = (in_op == OP_WRITE);
          mem_ctl.rd_en = (in_op == OP_READ);
        end
      end
      ST_RDA: begin
        mem_ctl.rd_en = 1'b1;
        mem_addr      = ABW'(pos_first[16:3]);
      end
      ST_RDB: begin
        mem_ctl.rd_en = 1'b1;
        mem_addr      = ABW'(pos_second[16:3]);
      end
      ST_EXEC: begin
        mem_ctl.wr_en = (op_r == OP_FILL) || (op_r == OP_MOVE);
        mem_addr      = ABW'(pos_second[16:3]);
        mem_wdata     = new_bit ? (mem_rdata | bmask) : (mem_rdata & ~bmask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            a1_r   <= in_first_bit_address;
            a2_r   <= in_second_bit_address;
            fill_r <= in_fill_bit;
            left_r <= in_bit_count;
            rd_r   <= '0;
            cmp_r  <= CMP_EQ;
            az_r   <= 1'b0;
            err_r  <= 1'b0;
            case (in_op) inside
              OP_WRITE: begin
                err_r    <= !byte_ok;
                strobe_r <= 1'b1;
              end
              OP_READ: begin
                if (byte_ok) begin
                  state_r <= ST_BREAD;
                end else begin
                  err_r    <= 1'b1;
                  strobe_r <= 1'b1;
                end
              end
              OP_FILL, OP_MOVE, OP_CMP, OP_ZERO: begin
                if (in_bit_count == '0) begin
                  az_r     <= (in_op == OP_ZERO);
                  strobe_r <= 1'b1;
                end else if (!fit1 || (!fit2 && (in_op == OP_MOVE || in_op == OP_CMP))) begin
                  err_r    <= 1'b1;
                  strobe_r <= 1'b1;
                end else begin
                  // move runs backward unless the source lies after the destination
                  if (in_op == OP_MOVE && !(in_second_bit_address > in_first_bit_address)) begin
                    fwd_r <= 1'b0;
                    off_r <= in_bit_count - 16'd1;
                  end else begin
                    fwd_r <= 1'b1;
                    off_r <= '0;
                  end
                  az_r    <= (in_op == OP_ZERO);
                  state_r <= ST_RDA;
                end
              end
              default: strobe_r <= 1'b1;
            endcase
          end
        end
        ST_BREAD: begin
          rd_r     <= mem_rdata;
          strobe_r <= 1'b1;
          state_r  <= ST_IDLE;
        end
        ST_RDA: begin
          state_r <= (op_r == OP_MOVE || op_r == OP_CMP) ? ST_RDB : ST_EXEC;
        end
        ST_RDB: begin
          bita_r  <= mem_rdata[3'd7 - pos_first[2:0]];
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (op_r == OP_ZERO && bit_b) begin
            az_r     <= 1'b0;
            strobe_r <= 1'b1;
            state_r  <= ST_IDLE;
          end else if (op_r == OP_CMP && bit_b != bita_r) begin
            cmp_r    <= bita_r ? CMP_GT : CMP_LT;
            strobe_r <= 1'b1;
            state_r  <= ST_IDLE;
          end else if (left_r == 16'd1) begin
            strobe_r <= 1'b1;
            state_r  <= ST_IDLE;
          end else begin
            left_r  <= left_r - 16'd1;
            off_r   <= fwd_r ? off_r + 16'd1 : off_r - 16'd1;
            state_r <= ST_RDA;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_strobe         = strobe_r;
  assign out_read_data      = rd_r;
  assign out_compare_result = cmp_r;
  assign out_all_zero       = az_r;
  assign out_range_error    = err_r;

endmodule

// ===== sv/bit_string_engine_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bit string engine: sequencer plus byte store.
// Depends on bse_pkg, bse_ctrl, bse_store.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start, busy        | in_operation .. in_fill_bit
//  result   | out_strobe (1 cyc) | out_read_data, out_compare_result,
//           |                    | out_all_zero, out_range_error
//
// Byte write, range errors and zero length: result the cycle after accept.
// Byte read: the store registers the byte, then the BREAD state copies it out.
// Fill and zero test step RDA, EXEC per bit; move and compare RDA, RDB, EXEC;
// all bound by the single store port (read, then read or write back).
// Reset clears control only; store contents are undefined until written.
// The receiver cannot stall; busy holds off new commands while one runs.
module bit_string_engine_unit #(
  parameter int STORE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [11:0]       in_byte_address,
  input  logic [7:0]        in_write_data,
  input  logic [14:0]       in_first_bit_address,
  input  logic [14:0]       in_second_bit_address,
  input  logic [15:0]       in_bit_count,
  input  logic              in_fill_bit,
  output logic              out_strobe,
  output logic [7:0]        out_read_data,
  output logic signed [1:0] out_compare_result,
  output logic              out_all_zero,
  output logic              out_range_error
);
  import bse_pkg::*;

  localparam int ABW = $clog2(STORE_BYTES);

  mem_ctl_t       mem_ctl;
  logic [ABW-1:0] mem_addr;
  logic [7:0]     mem_wdata, mem_rdata;

  bse_ctrl #(.STORE_BYTES(STORE_BYTES), .ABW(ABW)) u_ctrl (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_byte_address, .in_write_data,
    .in_first_bit_address, .in_second_bit_address, .in_bit_count, .in_fill_bit,
    .mem_ctl, .mem_addr, .mem_wdata, .mem_rdata,
    .out_strobe, .out_read_data, .out_compare_result, .out_all_zero,
    .out_range_error
  );

  bse_store #(.DEPTH(STORE_BYTES), .ABW(ABW)) u_store (
    .clk, .ctl(mem_ctl), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while sequencer still busy");

  a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_compare_result != 2'b10) else $error("bad compare code");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_range_error |-> !out_all_zero && out_compare_result == 2'b00
      && out_read_data == 8'h00) else $error("error result carries data");

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe || $past(start)) else $error("repeated result");

endmodule
